### rtl/kiwd_pkg.sv
// ----------------------------------------------------------------------------
// kiwd_pkg
// Shared types, constants and helpers for the keyspace index to word digits
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package kiwd_pkg;

  localparam int unsigned IdxW      = 32;
  localparam int unsigned LenW      = 5;
  localparam int unsigned AlphaW    = 9;
  localparam int unsigned PosW      = 4;
  localparam int unsigned DigitW    = 8;
  localparam int unsigned MaxLen    = 16;
  localparam int unsigned AlphaMax  = 256;
  localparam int unsigned RegIdxW   = 2;
  localparam int unsigned CfgDataW  = 9;

  localparam logic [RegIdxW-1:0] RegAlphabetSize = 2'd0;
  localparam logic [RegIdxW-1:0] RegMinLength    = 2'd1;
  localparam logic [RegIdxW-1:0] RegMaxLength    = 2'd2;
  localparam logic [RegIdxW-1:0] RegReserved     = 2'd3;

  typedef struct packed {
    logic [AlphaW-1:0] n;
    logic [LenW-1:0]   lo;
    logic [LenW-1:0]   hi;
  } cfg_t;

  typedef struct packed {
    logic              empty;
    logic [LenW-1:0]   len;
    logic [IdxW-1:0]   rem;
  } entry_t;

  function automatic logic [63:0] sat_mul(input logic [63:0] p, input logic [AlphaW-1:0] n);
    logic [63+AlphaW:0] prod;
    prod = p * {{64{1'b0}}, n};
    sat_mul = (prod[63+AlphaW:64] != '0) ? {64{1'b1}} : prod[63:0];
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

`default_nettype wire

### rtl/keyspace_index_to_word_digits.sv
// ----------------------------------------------------------------------------
// keyspace_index_to_word_digits
// Maps a keyspace index to per-position variant numbers of a candidate word.
// ----------------------------------------------------------------------------
// After reset and after every write to the alphabet size, min or max length
// register the keyspace total is rebuilt one length per cycle, with
// s_axis_tready low. Each accepted index then scans lengths from zero on the
// 64x9 saturating multiplier, up to the effective max_length, to find its
// bucket and then hands the entry to the queue, waiting while it is full; an
// out-of-range index or the empty word skips the scan. The digit side takes an
// entry and then, per position, runs four 8-bit restoring divide steps plus
// one output load, which waits for a free output register; an empty result
// skips the divide steps. The two sides overlap through a two-entry queue.
`default_nettype none

module keyspace_index_to_word_digits import kiwd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [RegIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [IdxW-1:0]     s_axis_tdata,   // word_index
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [15:0]              m_axis_tdata,   // variant_number, position
  output logic                     m_axis_tuser,   // empty_word
  output logic                     m_axis_tlast    // last_of_word
);

  cfg_t        cfg;
  logic [63:0] total;
  logic        total_busy, push, full, pop, fifo_empty;
  entry_t      f_ent, b_ent;

  kiwd_total u_total (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .cfg_o(cfg), .total_o(total), .busy_o(total_busy)
  );

  kiwd_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .cfg_i(cfg), .total_i(total), .total_busy_i(total_busy),
    .push_o(push), .entry_o(f_ent), .full_i(full)
  );

  kiwd_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_ent), .full_o(full),
    .pop_i(pop), .data_o(b_ent), .empty_o(fifo_empty)
  );

  kiwd_back u_back (
    .clk_i, .rst_ni, .entry_i(b_ent), .avail_i(!fifo_empty), .pop_o(pop),
    .n_i(cfg.n), .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .m_axis_tuser, .m_axis_tlast
  );

endmodule

`default_nettype wire

### rtl/kiwd_total.sv
// ----------------------------------------------------------------------------
// kiwd_total
// Configuration registers and sequential keyspace total recompute.
// ----------------------------------------------------------------------------
`default_nettype none

module kiwd_total import kiwd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [RegIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o,
  output logic [63:0]              total_o,
  output logic                     busy_o
);

  logic [AlphaW-1:0] alpha_q, alpha_d;
  logic [LenW-1:0]   minl_q, minl_d, maxl_q, maxl_d;
  logic              busy_q, busy_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [63:0]       pow_q, pow_d, sum_q, sum_d;
  cfg_t              cfg;

  always_comb begin
    cfg.n  = (alpha_q > AlphaW'(AlphaMax)) ? AlphaW'(AlphaMax) : alpha_q;
    cfg.lo = (minl_q > LenW'(MaxLen)) ? LenW'(MaxLen) : minl_q;
    cfg.hi = (maxl_q > LenW'(MaxLen)) ? LenW'(MaxLen) : maxl_q;
  end

  always_comb begin
    alpha_d = alpha_q;
    minl_d  = minl_q;
    maxl_d  = maxl_q;
    busy_d  = busy_q;
    len_d   = len_q;
    pow_d   = pow_q;
    sum_d   = sum_q;
    if (busy_q) begin
      if (len_q >= cfg.lo) begin
        sum_d = sat_add(sum_q, pow_q);
      end
      if (len_q >= cfg.hi) begin
        busy_d = 1'b0;
      end else begin
        len_d = len_q + LenW'(1);
        pow_d = sat_mul(pow_q, cfg.n);
      end
    end
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegAlphabetSize: alpha_d = cfg_data_i[AlphaW-1:0];
        RegMinLength:    minl_d  = cfg_data_i[LenW-1:0];
        RegMaxLength:    maxl_d  = cfg_data_i[LenW-1:0];
        default: ;
      endcase
      if (cfg_index_i == RegAlphabetSize || cfg_index_i == RegMinLength ||
          cfg_index_i == RegMaxLength) begin
        busy_d = 1'b1;
        len_d  = '0;
        pow_d  = 64'd1;
        sum_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= AlphaW'(1);
      minl_q  <= LenW'(1);
      maxl_q  <= LenW'(1);
      busy_q  <= 1'b1;
      len_q   <= '0;
      pow_q   <= 64'd1;
      sum_q   <= '0;
    end else begin
      alpha_q <= alpha_d;
      minl_q  <= minl_d;
      maxl_q  <= maxl_d;
      busy_q  <= busy_d;
      len_q   <= len_d;
      pow_q   <= pow_d;
      sum_q   <= sum_d;
    end
  end

  assign cfg_o   = cfg;
  assign total_o = sum_q;
  assign busy_o  = busy_q;

endmodule

`default_nettype wire

### rtl/kiwd_front.sv
// ----------------------------------------------------------------------------
// kiwd_front
// Accepts indexes, range-checks them and finds the length bucket.
// ----------------------------------------------------------------------------
`default_nettype none

module kiwd_front import kiwd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [IdxW-1:0] s_axis_tdata,    // word_index
  input  wire cfg_t            cfg_i,
  input  wire logic [63:0]     total_i,
  input  wire logic            total_busy_i,
  output logic                 push_o,
  output entry_t               entry_o,
  input  wire logic            full_i
);

  typedef enum logic [1:0] {StIdle, StSearch, StPush} state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] rem_q, rem_d;
  logic [LenW-1:0] len_q, len_d;
  logic [63:0]     pow_q, pow_d;
  entry_t          ent_q, ent_d;
  logic            in_bucket;

  assign s_axis_tready = (state_q == StIdle) && !total_busy_i;
  assign in_bucket     = len_q >= cfg_i.lo;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    len_d   = len_q;
    pow_d   = pow_q;
    ent_d   = ent_q;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          rem_d = s_axis_tdata;
          len_d = '0;
          pow_d = 64'd1;
          ent_d = '{empty: 1'b1, len: '0, rem: '0};
          if ({32'd0, s_axis_tdata} >= total_i ||
              (s_axis_tdata == '0 && cfg_i.lo == '0)) begin
            state_d = StPush;
          end else begin
            state_d = StSearch;
          end
        end
      end
      StSearch: begin
        if (in_bucket && {32'd0, rem_q} < pow_q) begin
          ent_d.empty = (len_q == '0) || (cfg_i.n == '0);
          ent_d.len   = len_q;
          ent_d.rem   = rem_q;
          state_d     = StPush;
        end else begin
          if (in_bucket) begin
            rem_d = rem_q - pow_q[IdxW-1:0];
          end
          if (len_q >= cfg_i.hi) begin
            state_d = StPush;
          end else begin
            len_d = len_q + LenW'(1);
            pow_d = sat_mul(pow_q, cfg_i.n);
          end
        end
      end
      StPush: begin
        if (!full_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    len_q <= len_d;
    pow_q <= pow_d;
    ent_q <= ent_d;
  end

  assign push_o  = (state_q == StPush) && !full_i;
  assign entry_o = ent_q;

endmodule

`default_nettype wire

### rtl/kiwd_fifo.sv
// ----------------------------------------------------------------------------
// kiwd_fifo
// Two-entry queue between bucket search and digit generation.
// ----------------------------------------------------------------------------
`default_nettype none

module kiwd_fifo import kiwd_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t data_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output entry_t      data_o,
  output logic        empty_o
);

  entry_t     mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

`default_nettype wire

### rtl/kiwd_back.sv
// ----------------------------------------------------------------------------
// kiwd_back
// Generates base-N digits, least significant first, with an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kiwd_back import kiwd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire entry_t            entry_i,
  input  wire logic              avail_i,
  output logic                   pop_o,
  input  wire logic [AlphaW-1:0] n_i,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [15:0]            m_axis_tdata,  // variant_number, position
  output logic                   m_axis_tuser,  // empty_word
  output logic                   m_axis_tlast   // last_of_word
);

  typedef enum logic [1:0] {StIdle, StDiv, StEmit} state_e;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   quo_q, quo_d;
  logic [AlphaW-1:0] r_q, r_d;
  logic [1:0]        step_q, step_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              emp_q, emp_d;
  logic              ov_q, ov_d;
  logic [DigitW-1:0] od_q, od_d;
  logic [PosW-1:0]   op_q, op_d;
  logic              oe_q, oe_d, ol_q, ol_d;
  logic              is_last, out_free;

  assign out_free = !ov_q || m_axis_tready;
  assign is_last  = emp_q || ({1'b0, pos_q} + 5'd1 == len_q);

  always_comb begin
    logic [IdxW-1:0]   a;
    logic [AlphaW-1:0] r;
    logic [AlphaW-1:0] t;
    state_d = state_q;
    quo_d   = quo_q;
    r_d     = r_q;
    step_d  = step_q;
    len_d   = len_q;
    pos_d   = pos_q;
    emp_d   = emp_q;
    ov_d    = ov_q && !m_axis_tready;
    od_d    = od_q;
    op_d    = op_q;
    oe_d    = oe_q;
    ol_d    = ol_q;
    pop_o   = 1'b0;
    a = quo_q;
    r = r_q;
    for (int i = 0; i < 8; i++) begin
      t = {r[7:0], a[IdxW-1]};
      a = {a[IdxW-2:0], t >= n_i};
      r = (t >= n_i) ? t - n_i : t;
    end
    case (state_q)
      StIdle: begin
        if (avail_i) begin
          pop_o  = 1'b1;
          quo_d  = entry_i.rem;
          len_d  = entry_i.len;
          emp_d  = entry_i.empty;
          pos_d  = '0;
          r_d    = '0;
          step_d = '0;
          state_d = entry_i.empty ? StEmit : StDiv;
        end
      end
      StDiv: begin
        quo_d  = a;
        r_d    = r;
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) state_d = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          ov_d = 1'b1;
          od_d = r_q[DigitW-1:0];
          op_d = pos_q;
          oe_d = emp_q;
          ol_d = is_last;
          if (is_last) begin
            state_d = StIdle;
          end else begin
            pos_d  = pos_q + PosW'(1);
            r_d    = '0;
            step_d = '0;
            state_d = StDiv;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    r_q    <= r_d;
    step_q <= step_d;
    len_q  <= len_d;
    pos_q  <= pos_d;
    emp_q  <= emp_d;
    od_q   <= od_d;
    op_q   <= op_d;
    oe_q   <= oe_d;
    ol_q   <= ol_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'd0, op_q, od_q};
  assign m_axis_tuser  = oe_q;
  assign m_axis_tlast  = ol_q;

endmodule

`default_nettype wire

### dv/kiwd_checker.sv
// ----------------------------------------------------------------------------
// kiwd_checker
// Watches the index and digit streams of the keyspace index to word digits
// block, predicts the digits of every accepted index and compares each
// output transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kiwd_checker import kiwd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [RegIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_valid_i,
  input  wire logic                s_ready_i,
  input  wire logic [IdxW-1:0]     s_data_i,
  input  wire logic                m_valid_i,
  input  wire logic                m_ready_i,
  input  wire logic [15:0]         m_data_i,
  input  wire logic                m_user_i,
  input  wire logic                m_last_i,
  output int                       errors_o,
  output int                       pending_o,
  output int                       digits_seen_o,
  output int                       empties_seen_o
);

  typedef struct packed {
    logic [DigitW-1:0] variant;
    logic [PosW-1:0]   pos;
    logic              empty;
    logic              last;
  } digit_t;

  digit_t digit_q[$];
  logic [8:0] alpha_r;
  logic [4:0] min_len_r, max_len_r;

  function automatic logic [63:0] pow_sat(input logic [63:0] base, input int unsigned ex);
    logic [127:0] p;
    p = 1;
    for (int unsigned i = 0; i < ex; i++) begin
      p = p * base;
      if (p[127:64] != 0) return '1;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] keyspace_size(input logic [63:0] n,
                                                input int unsigned lo, input int unsigned hi);
    logic [64:0] sum;
    sum = 0;
    for (int unsigned l = lo; l <= hi; l++) begin
      sum = sum + pow_sat(n, l);
      if (sum[64]) sum = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
    end
    return sum[63:0];
  endfunction

  task automatic predict_word(input logic [IdxW-1:0] idx);
    logic [63:0] n, rem, b, total;
    int unsigned lo, hi, len;
    bit found;
    digit_t d;
    n = (alpha_r > AlphaMax) ? AlphaMax : alpha_r;
    lo = (min_len_r > MaxLen) ? MaxLen : min_len_r;
    hi = (max_len_r > MaxLen) ? MaxLen : max_len_r;
    rem = {32'd0, idx};
    found = 0;
    total = keyspace_size(n, lo, hi);
    d = '{variant: '0, pos: '0, empty: 1'b1, last: 1'b1};
    if (rem >= total || (rem == 0 && lo == 0)) begin
      digit_q.push_back(d);
      return;
    end
    for (len = lo; len <= hi; len++) begin
      b = pow_sat(n, len);
      if (rem < b) begin
        found = 1;
        break;
      end
      rem -= b;
    end
    if (!found || len == 0 || n == 0) begin
      digit_q.push_back(d);
      return;
    end
    for (int unsigned i = 0; i < len; i++) begin
      d.variant = DigitW'(rem % n);
      rem = rem / n;
      d.pos = PosW'(i);
      d.empty = 1'b0;
      d.last = (i + 1 == len);
      digit_q.push_back(d);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digit_t got, want;
    if (!rst_ni) begin
      alpha_r <= 9'd1;
      min_len_r <= 5'd1;
      max_len_r <= 5'd1;
      errors_o <= 0;
      digits_seen_o <= 0;
      empties_seen_o <= 0;
      digit_q.delete();
    end else begin
      if (m_valid_i && m_ready_i) begin
        got = '{variant: m_data_i[7:0], pos: m_data_i[11:8], empty: m_user_i,
                last: m_last_i};
        if (got.empty) empties_seen_o <= empties_seen_o + 1;
        else digits_seen_o <= digits_seen_o + 1;
        if (digit_q.size() == 0) begin
          $display("%0t: unexpected digit transfer %p", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          want = digit_q.pop_front();
          if (got !== want || m_data_i[15:12] !== 4'd0) begin
            $display("%0t: mismatch expected %p actual %p (tdata %h)", $time, want, got,
                     m_data_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (s_valid_i && s_ready_i) predict_word(s_data_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegAlphabetSize: alpha_r <= cfg_data_i;
          RegMinLength:    min_len_r <= cfg_data_i[4:0];
          RegMaxLength:    max_len_r <= cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
  end

  assign pending_o = digit_q.size();

endmodule

`default_nettype wire

### dv/tb_keyspace_index_to_word_digits.sv
// ----------------------------------------------------------------------------
// tb_keyspace_index_to_word_digits
// Drives indexes under a series of alphabet and length settings with random
// gaps and back-pressure; the checker predicts and compares every digit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_keyspace_index_to_word_digits;
  import kiwd_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [RegIdxW-1:0] cfg_index_i = RegAlphabetSize;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IdxW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic m_axis_tuser, m_axis_tlast;
  int errors, pending, digits_seen, empties_seen;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 0;
  longint cycles = 0;
  int words_sent = 0, settings_run = 0;
  logic [63:0] cur_total;

  always #2 clk_i = ~clk_i;

  keyspace_index_to_word_digits u_top (.*);

  kiwd_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .m_user_i(m_axis_tuser), .m_last_i(m_axis_tlast),
    .errors_o(errors), .pending_o(pending), .digits_seen_o(digits_seen),
    .empties_seen_o(empties_seen)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic wr_reg(input logic [RegIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // drops the input valid, then waits for every predicted result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic configure(input logic [8:0] n, input logic [4:0] lo, input logic [4:0] hi);
    logic [63:0] p;
    logic [64:0] s;
    drain();
    wr_reg(RegAlphabetSize, n);
    wr_reg(RegMinLength, CfgDataW'(lo));
    wr_reg(RegMaxLength, CfgDataW'(hi));
    s = 0;
    for (int l = (lo > 16 ? 16 : lo); l <= (hi > 16 ? 16 : hi); l++) begin
      p = 1;
      for (int i = 0; i < l; i++) p = (p == 0) ? 0 : p * ((n > 256) ? 256 : n);
      s = s + p;
    end
    cur_total = (s > 64'hFFFF_FFFF) ? 64'h1_0000_0000 : s[63:0];
    settings_run++;
  endtask

  // leaves tvalid high after the transfer; the next gap or drain drops it
  task automatic send_word(input logic [IdxW-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= idx;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  function automatic logic [IdxW-1:0] pick_index();
    int r;
    r = $urandom_range(9);
    if (r == 0) return $urandom;
    if (r == 1) return (cur_total == 0) ? '0 : IdxW'(cur_total - 1);
    if (r == 2) return cur_total[31:0];
    if (cur_total > 64'hFFFF_FFFF) return $urandom;
    return (cur_total == 0) ? IdxW'($urandom_range(3)) : IdxW'($urandom % cur_total);
  endfunction

  task automatic random_block(input int count);
    for (int i = 0; i < count; i++) send_word(pick_index());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    cur_total = 1;
    send_word(0);
    send_word(1);
    configure(9'd3, 5'd0, 5'd2);
    send_word(0);
    send_word(1);
    send_word(12);
    send_word(13);
    send_word(14);
    configure(9'd256, 5'd16, 5'd16);
    send_word('1);
    send_word(32'h5555_AAAA);
    send_word(0);
    configure(9'd511, 5'd31, 5'd3);
    send_word(0);
    send_word(7);
    configure(9'd0, 5'd0, 5'd4);
    send_word(0);
    send_word(1);
    configure(9'd2, 5'd0, 5'd31);
    send_word(0);
    send_word(1);
    send_word(2);
    send_word(32'hFFFF_FFFF);
    configure(9'd1, 5'd0, 5'd16);
    send_word(16);
    send_word(17);
    drain();
    wr_reg(RegReserved, 9'h1FF);

    // long receiver hold-off with the sender still offering
    hold_off = 1;
    fork
      begin
        random_block(10);
        drain();
      end
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
    join

    send_idle_pct = 8;
    recv_idle_pct = 77;
    for (int k = 0; k < 4; k++) begin
      configure(AlphaW'($urandom_range(2, 300)), LenW'($urandom_range(0, 4)),
                LenW'($urandom_range(1, 6)));
      random_block(25);
    end
    send_idle_pct = 77;
    recv_idle_pct = 8;
    for (int k = 0; k < 4; k++) begin
      configure(AlphaW'($urandom_range(0, 511)), LenW'($urandom_range(0, 17)),
                LenW'($urandom_range(0, 17)));
      random_block(25);
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(9'd16, 5'd1, 5'd8);
    random_block(50);
    drain();
    configure(9'd7, 5'd2, 5'd5);
    random_block(40);
    drain();
    $display("Covered %0d indexes over %0d settings: %0d digits and %0d empty results checked.",
             words_sent, settings_run, digits_seen, empties_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
